[design/wsenc_pkg.sv]
// ----------------------------------------------------------------------------
// wsenc_pkg
// Shared types, codes and constants of the WS2812 SPI frame encoder.
// ----------------------------------------------------------------------------
package wsenc_pkg;

    localparam int LED_COUNT = 4;
    localparam int MAX_LEDS  = 21;
    localparam int LEDS      = (LED_COUNT > MAX_LEDS) ? MAX_LEDS : LED_COUNT;
    localparam int LED_W     = (LEDS > 1) ? $clog2(LEDS) : 1;
    localparam logic [LED_W-1:0] LED_LAST = LED_W'(LEDS - 1);
    localparam logic GAP_LAST = (LEDS == 0);

    localparam logic [7:0]  GAP_BYTES   = 8'd90;
    localparam logic [15:0] LEVEL_RESET = 16'd19275;
    localparam logic [3:0]  NIB_ZERO    = 4'b1000;
    localparam logic [3:0]  NIB_ONE     = 4'b1110;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        CMD_ON      = 3'd0,
        CMD_OFF     = 3'd1,
        CMD_TOGGLE  = 3'd2,
        CMD_SET     = 3'd3,
        CMD_REFRESH = 3'd4,
        CMD_QUERY   = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_GAP    = 2'd1,
        KIND_DATA   = 2'd2
    } kind_t;

    // One queued job: what to emit plus the state snapshot it reports
    typedef struct packed {
        logic        refresh;
        logic        on;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } job_t;

    // Each bit, MSB first, becomes one nibble of the SPI word
    function automatic logic [31:0] encode_byte(input logic [7:0] v);
        logic [31:0] w;
        w = '0;
        for (int i = 0; i < 8; i++) begin
            w[4*i +: 4] = v[i] ? NIB_ONE : NIB_ZERO;
        end
        return w;
    endfunction

endpackage

[design/wsenc_front.sv]
// ----------------------------------------------------------------------------
// wsenc_front
// Accepts command words, updates the light state and queues one job per
// command with a snapshot of the state after the command.
// ----------------------------------------------------------------------------
module wsenc_front
    import wsenc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [15:0] red_in,
    input  logic [15:0] green_in,
    input  logic [15:0] blue_in,
    input  logic        q_full,
    output logic        push,
    output job_t        push_job
);

    logic        on_reg,    on_next;
    logic [15:0] red_reg,   red_next;
    logic [15:0] green_reg, green_next;
    logic [15:0] blue_reg,  blue_next;
    logic        refresh;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        on_next    = on_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        refresh    = 1'b0;
        case (command)
            CMD_ON:      on_next = 1'b1;
            CMD_OFF:     on_next = 1'b0;
            CMD_TOGGLE:  on_next = !on_reg;
            CMD_SET:
            begin
                red_next   = red_in;
                green_next = green_in;
                blue_next  = blue_in;
            end
            CMD_REFRESH: refresh = 1'b1;
            default:     refresh = 1'b0;
        endcase
    end

    assign push_job = '{refresh: refresh, on: on_next, red: red_next,
                        green: green_next, blue: blue_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg    <= 1'b0;
            red_reg   <= LEVEL_RESET;
            green_reg <= LEVEL_RESET;
            blue_reg  <= LEVEL_RESET;
        end
        else if (push)
        begin
            on_reg    <= on_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

endmodule

[design/wsenc_queue.sv]
// ----------------------------------------------------------------------------
// wsenc_queue
// Short job queue between the command front and the frame back end.
// ----------------------------------------------------------------------------
module wsenc_queue
    import wsenc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output job_t pop_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    job_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign pop_job   = mem[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[design/wsenc_back.sv]
// ----------------------------------------------------------------------------
// wsenc_back
// Expands queued jobs into result words: one status word, or a reset gap
// followed by green, red, blue data words for every LED.
// ----------------------------------------------------------------------------
module wsenc_back
    import wsenc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_not_empty,
    input  job_t        q_job,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [31:0] spi_word,
    output logic [7:0]  gap_bytes,
    output logic        led_is_on,
    output logic [15:0] red_now,
    output logic [15:0] green_now,
    output logic [15:0] blue_now,
    output logic        last
);

    typedef enum logic { PH_GAP, PH_DATA } phase_t;
    typedef enum logic [1:0] { COL_G, COL_R, COL_B } colour_t;

    job_t             job_reg,    job_next;
    logic             jvalid_reg, jvalid_next;
    phase_t           phase_reg,  phase_next;
    colour_t          col_reg,    col_next;
    logic [LED_W-1:0] led_reg,    led_next;

    logic             ovalid_reg, ovalid_next;
    kind_t            kind_reg,   kind_next;
    logic [31:0]      word_reg,   word_next;
    logic [7:0]       gap_reg,    gap_next;
    logic             last_reg,   last_next;
    job_t             snap_reg,   snap_next;

    logic             emit;
    kind_t            res_kind;
    logic [31:0]      res_word;
    logic [7:0]       res_gap;
    logic             res_last;
    logic [7:0]       level_byte;

    assign emit = jvalid_reg && (!ovalid_reg || !out_stall);
    assign pop  = q_not_empty && (!jvalid_reg || (emit && res_last));

    // Pick this word's colour byte; zero while the light is off
    always_comb
    begin
        case (col_reg)
            COL_G:   level_byte = job_reg.green[15:8];
            COL_R:   level_byte = job_reg.red[15:8];
            COL_B:   level_byte = job_reg.blue[15:8];
            default: level_byte = 8'd0;
        endcase
        if (!job_reg.on)
        begin
            level_byte = 8'd0;
        end
    end

    always_comb
    begin
        res_kind = KIND_STATUS;
        res_word = '0;
        res_gap  = '0;
        res_last = 1'b1;
        if (job_reg.refresh)
        begin
            if (phase_reg == PH_GAP)
            begin
                res_kind = KIND_GAP;
                res_gap  = GAP_BYTES;
                res_last = GAP_LAST;
            end
            else
            begin
                res_kind = KIND_DATA;
                res_word = encode_byte(level_byte);
                res_last = (col_reg == COL_B) && (led_reg == LED_LAST);
            end
        end
    end

    always_comb
    begin
        job_next    = job_reg;
        jvalid_next = jvalid_reg;
        phase_next  = phase_reg;
        col_next    = col_reg;
        led_next    = led_reg;
        ovalid_next = ovalid_reg;
        kind_next   = kind_reg;
        word_next   = word_reg;
        gap_next    = gap_reg;
        last_next   = last_reg;
        snap_next   = snap_reg;

        if (emit)
        begin
            ovalid_next = 1'b1;
            kind_next   = res_kind;
            word_next   = res_word;
            gap_next    = res_gap;
            last_next   = res_last;
            snap_next   = job_reg;
            if (res_last)
            begin
                jvalid_next = 1'b0;
            end
            else if (phase_reg == PH_GAP)
            begin
                phase_next = PH_DATA;
                col_next   = COL_G;
                led_next   = '0;
            end
            else
            begin
                case (col_reg)
                    COL_G:   col_next = COL_R;
                    COL_R:   col_next = COL_B;
                    default:
                    begin
                        col_next = COL_G;
                        led_next = led_reg + 1'b1;
                    end
                endcase
            end
        end
        else if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end

        if (pop)
        begin
            job_next    = q_job;
            jvalid_next = 1'b1;
            phase_next  = PH_GAP;
            col_next    = COL_G;
            led_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_reg    <= '0;
            jvalid_reg <= 1'b0;
            phase_reg  <= PH_GAP;
            col_reg    <= COL_G;
            led_reg    <= '0;
            ovalid_reg <= 1'b0;
            kind_reg   <= KIND_STATUS;
            word_reg   <= '0;
            gap_reg    <= '0;
            last_reg   <= 1'b0;
            snap_reg   <= '0;
        end
        else
        begin
            job_reg    <= job_next;
            jvalid_reg <= jvalid_next;
            phase_reg  <= phase_next;
            col_reg    <= col_next;
            led_reg    <= led_next;
            ovalid_reg <= ovalid_next;
            kind_reg   <= kind_next;
            word_reg   <= word_next;
            gap_reg    <= gap_next;
            last_reg   <= last_next;
            snap_reg   <= snap_next;
        end
    end

    assign out_valid = ovalid_reg;
    assign kind      = kind_reg;
    assign spi_word  = word_reg;
    assign gap_bytes = gap_reg;
    assign led_is_on = snap_reg.on;
    assign red_now   = snap_reg.red;
    assign green_now = snap_reg.green;
    assign blue_now  = snap_reg.blue;
    assign last      = last_reg;

endmodule

[design/ws2812_spi_frame_encoder_unit.sv]
// ----------------------------------------------------------------------------
// ws2812_spi_frame_encoder_unit
// Light controller that turns on/off/colour/refresh commands into WS2812
// SPI frame words.
// ----------------------------------------------------------------------------
// A command word is taken whenever the two-entry job queue has room, so
// commands may arrive back to back. The back end then delivers one result
// word per cycle while the output is not stalled: a status command gives
// one word, a refresh gives a reset-gap word followed by three data words
// (green, red, blue) per LED, i.e. 1 + 3 * LEDS words, 13 at four LEDs.
// That per-word emission in the back end sets the sustained rate; the output
// register holds a word while it waits. Every word reports the on/off flag
// and levels as they stand after its command.
module ws2812_spi_frame_encoder_unit
    import wsenc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [15:0] red_in,
    input  logic [15:0] green_in,
    input  logic [15:0] blue_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [31:0] spi_word,
    output logic [7:0]  gap_bytes,
    output logic        led_is_on,
    output logic [15:0] red_now,
    output logic [15:0] green_now,
    output logic [15:0] blue_now,
    output logic        last
);

    logic push;
    job_t push_job;
    logic q_full;
    logic q_not_empty;
    job_t q_job;
    logic pop;

    wsenc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .red_in   (red_in),
        .green_in (green_in),
        .blue_in  (blue_in),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    wsenc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop_job   (q_job)
    );

    wsenc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_job       (q_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .spi_word    (spi_word),
        .gap_bytes   (gap_bytes),
        .led_is_on   (led_is_on),
        .red_now     (red_now),
        .green_now   (green_now),
        .blue_now    (blue_now),
        .last        (last)
    );

endmodule

[design/wsenc_checker.sv]
// ----------------------------------------------------------------------------
// wsenc_checker
// Port-level checks on the frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
module wsenc_checker
    import wsenc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [31:0] spi_word,
    input logic        led_is_on,
    input logic        last
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(spi_word) && $stable(kind))
        else $error("stalled output word dropped or changed");

    // Dark LEDs encode byte zero
    a_dark_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_DATA) && !led_is_on |-> spi_word == 32'h88888888)
        else $error("data word while off is not all zero bits");

    // Advance from a taken gap word straight into data words
    a_gap_then_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && (kind == KIND_GAP) && !last
        |=> out_valid && (kind == KIND_DATA))
        else $error("gap word not followed by data word");

    // Status words close their command
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_STATUS) |-> last && (spi_word == '0))
        else $error("status word malformed");

endmodule

bind ws2812_spi_frame_encoder_unit wsenc_checker u_checker (.*);

[bench/ws2812_spi_frame_encoder_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ws2812_spi_frame_encoder_unit_test
// Self-checking bench for the WS2812 SPI frame encoder. Light commands are
// sent through a random-idling driver. A predictor keeps its own copy of the
// on/off flag and colour levels and queues the status, reset-gap and colour
// words that each accepted command should produce. A monitor checks every
// output word field by field against that queue.
// ----------------------------------------------------------------------------
module ws2812_spi_frame_encoder_unit_test;
    import wsenc_pkg::*;

    localparam int          HALF_PERIOD  = 5;
    localparam int          RESET_CYCLES = 9;
    localparam int          RUN_LIMIT    = 200000;
    localparam int          TAIL_CYCLES  = 50;
    localparam int          RANDOM_CMDS  = 230;
    localparam int          REPORT_MAX   = 10;
    // Codes left over in the command field; the block treats them as a query
    localparam logic [2:0]  CMD_SPARE_LO = 3'd6;
    localparam logic [2:0]  CMD_SPARE_HI = 3'd7;
    localparam logic [15:0] LEVEL_MAX    = 16'hFFFF;
    localparam logic [15:0] LEVEL_MIN    = 16'h0000;

    typedef struct {
        logic [2:0]  code;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } light_cmd_t;

    typedef struct {
        kind_t       kind;
        logic [31:0] word;
        logic [7:0]  gap;
        logic        on;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        last;
    } light_word_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  command;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [31:0] spi_word;
    logic [7:0]  gap_bytes;
    logic        led_is_on;
    logic [15:0] red_now;
    logic [15:0] green_now;
    logic [15:0] blue_now;
    logic        last;

    light_cmd_t  cmds_to_send[$];
    light_word_t light_words_due[$];
    light_cmd_t  next_cmd;
    light_word_t due_word;

    // Predicted light state
    logic        lamp_on;
    logic [15:0] lvl_red;
    logic [15:0] lvl_green;
    logic [15:0] lvl_blue;

    int cycle_count;
    int cmds_issued;
    int cmds_accepted;
    int words_checked;
    int refreshes_seen;
    int mismatches;
    logic calm;

    ws2812_spi_frame_encoder_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .spi_word  (spi_word),
        .gap_bytes (gap_bytes),
        .led_is_on (led_is_on),
        .red_now   (red_now),
        .green_now (green_now),
        .blue_now  (blue_now),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // No idling on either side for a stretch in the middle of the run
    assign calm = (cmds_accepted >= 90) && (cmds_accepted < 150);

    // Build the SPI word for one colour byte, MSB first, one nibble per bit
    function automatic logic [31:0] spi_nibbles_of(input logic [7:0] level_byte);
        logic [31:0] acc;
        acc = '0;
        for (int b = 7; b >= 0; b--)
        begin
            acc = {acc[27:0], level_byte[b] ? NIB_ONE : NIB_ZERO};
        end
        return acc;
    endfunction

    function automatic light_word_t light_word(input kind_t k, input logic [31:0] w,
                                               input logic [7:0] g, input logic lst);
        light_word_t r;
        r.kind  = k;
        r.word  = w;
        r.gap   = g;
        r.on    = lamp_on;
        r.red   = lvl_red;
        r.green = lvl_green;
        r.blue  = lvl_blue;
        r.last  = lst;
        return r;
    endfunction

    // Update the light state for one command and queue the words it produces
    task automatic predict_light_words(input light_cmd_t c);
        logic [31:0] g_word;
        logic [31:0] r_word;
        logic [31:0] b_word;
        case (c.code)
            CMD_ON:     lamp_on = 1'b1;
            CMD_OFF:    lamp_on = 1'b0;
            CMD_TOGGLE: lamp_on = ~lamp_on;
            CMD_SET:
            begin
                lvl_red   = c.red;
                lvl_green = c.green;
                lvl_blue  = c.blue;
            end
            default: ;
        endcase
        if (c.code == CMD_REFRESH)
        begin
            // A dark lamp still sends full frames, all encoding zero
            g_word = spi_nibbles_of(lamp_on ? lvl_green[15:8] : 8'h00);
            r_word = spi_nibbles_of(lamp_on ? lvl_red[15:8] : 8'h00);
            b_word = spi_nibbles_of(lamp_on ? lvl_blue[15:8] : 8'h00);
            light_words_due.push_back(light_word(KIND_GAP, '0, GAP_BYTES, LEDS == 0));
            for (int led = 0; led < LEDS; led++)
            begin
                light_words_due.push_back(light_word(KIND_DATA, g_word, '0, 1'b0));
                light_words_due.push_back(light_word(KIND_DATA, r_word, '0, 1'b0));
                light_words_due.push_back(light_word(KIND_DATA, b_word, '0,
                                                     led == LEDS - 1));
            end
        end
        else
        begin
            light_words_due.push_back(light_word(KIND_STATUS, '0, '0, 1'b1));
        end
    endtask

    task automatic queue_cmd(input logic [2:0] code, input logic [15:0] r,
                             input logic [15:0] g, input logic [15:0] b);
        light_cmd_t c;
        c.code  = code;
        c.red   = r;
        c.green = g;
        c.blue  = b;
        cmds_to_send.push_back(c);
    endtask

    function automatic logic [15:0] random_level();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return LEVEL_MIN;
        else if (pick == 1)
            return LEVEL_MAX;
        else
            return 16'($urandom);
    endfunction

    function automatic logic [2:0] random_code();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25)
            return CMD_SET;
        else if (pick < 45)
            return CMD_REFRESH;
        else if (pick < 57)
            return CMD_ON;
        else if (pick < 67)
            return CMD_OFF;
        else if (pick < 79)
            return CMD_TOGGLE;
        else if (pick < 91)
            return CMD_QUERY;
        else if (pick < 96)
            return CMD_SPARE_LO;
        else
            return CMD_SPARE_HI;
    endfunction

    // Driver: present the next word once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= !calm && ($urandom_range(99) < 7);
            if (cmds_accepted == cmds_issued)
            begin
                if (cmds_to_send.size() != 0 && (calm || $urandom_range(99) >= 7))
                begin
                    next_cmd = cmds_to_send.pop_front();
                    in_valid    <= 1'b1;
                    command     <= next_cmd.code;
                    red_in      <= next_cmd.red;
                    green_in    <= next_cmd.green;
                    blue_in     <= next_cmd.blue;
                    cmds_issued <= cmds_issued + 1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check output words first, then predict from the accepted command
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (light_words_due.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < REPORT_MAX)
                        $display("[%0t] unexpected word: kind %0d spi %h gap %0d", $realtime,
                                 kind, spi_word, gap_bytes);
                end
                else
                begin
                    due_word = light_words_due.pop_front();
                    words_checked <= words_checked + 1;
                    if (kind !== due_word.kind || spi_word !== due_word.word ||
                        gap_bytes !== due_word.gap || led_is_on !== due_word.on ||
                        red_now !== due_word.red || green_now !== due_word.green ||
                        blue_now !== due_word.blue || last !== due_word.last)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < REPORT_MAX)
                        begin
                            $display("[%0t] mismatch exp: kind %0d spi %h gap %0d on %b rgb %h %h %h last %b",
                                     $realtime, due_word.kind, due_word.word, due_word.gap,
                                     due_word.on, due_word.red, due_word.green,
                                     due_word.blue, due_word.last);
                            $display("            got: kind %0d spi %h gap %0d on %b rgb %h %h %h last %b",
                                     kind, spi_word, gap_bytes, led_is_on, red_now,
                                     green_now, blue_now, last);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                next_cmd.code  = command;
                next_cmd.red   = red_in;
                next_cmd.green = green_in;
                next_cmd.blue  = blue_in;
                predict_light_words(next_cmd);
                cmds_accepted <= cmds_accepted + 1;
                if (command == CMD_REFRESH)
                    refreshes_seen <= refreshes_seen + 1;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        out_stall      = 1'b0;
        command        = CMD_QUERY;
        red_in         = '0;
        green_in       = '0;
        blue_in        = '0;
        cycle_count    = 0;
        cmds_issued    = 0;
        cmds_accepted  = 0;
        words_checked  = 0;
        refreshes_seen = 0;
        mismatches     = 0;
        lamp_on        = 1'b0;
        lvl_red        = LEVEL_RESET;
        lvl_green      = LEVEL_RESET;
        lvl_blue       = LEVEL_RESET;

        // Directed: reset state, dark refresh, extremes, every code
        queue_cmd(CMD_QUERY,    LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
        queue_cmd(CMD_REFRESH,  LEVEL_MIN, LEVEL_MIN, LEVEL_MIN);
        queue_cmd(CMD_ON,       LEVEL_MIN, LEVEL_MAX, LEVEL_MIN);
        queue_cmd(CMD_REFRESH,  LEVEL_MAX, LEVEL_MIN, LEVEL_MAX);
        queue_cmd(CMD_SET,      LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
        queue_cmd(CMD_REFRESH,  LEVEL_MIN, LEVEL_MIN, LEVEL_MIN);
        queue_cmd(CMD_SET,      LEVEL_MIN, LEVEL_MIN, LEVEL_MIN);
        queue_cmd(CMD_REFRESH,  LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
        queue_cmd(CMD_SET,      16'hA55A, 16'h5AA5, 16'h80FF);
        queue_cmd(CMD_REFRESH,  LEVEL_MIN, LEVEL_MIN, LEVEL_MIN);
        queue_cmd(CMD_TOGGLE,   LEVEL_MIN, LEVEL_MIN, LEVEL_MIN);
        queue_cmd(CMD_REFRESH,  LEVEL_MIN, LEVEL_MIN, LEVEL_MIN);
        queue_cmd(CMD_TOGGLE,   LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
        queue_cmd(CMD_QUERY,    LEVEL_MIN, LEVEL_MIN, LEVEL_MIN);
        queue_cmd(CMD_SPARE_LO, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
        queue_cmd(CMD_SPARE_HI, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
        queue_cmd(CMD_OFF,      LEVEL_MIN, LEVEL_MIN, LEVEL_MIN);
        queue_cmd(CMD_OFF,      LEVEL_MIN, LEVEL_MIN, LEVEL_MIN);
        queue_cmd(CMD_TOGGLE,   LEVEL_MIN, LEVEL_MIN, LEVEL_MIN);
        queue_cmd(CMD_SET,      16'h01FE, 16'hFE01, 16'h7F00);
        queue_cmd(CMD_REFRESH,  LEVEL_MIN, LEVEL_MIN, LEVEL_MIN);
        queue_cmd(CMD_REFRESH,  LEVEL_MIN, LEVEL_MIN, LEVEL_MIN);

        for (int n = 0; n < RANDOM_CMDS; n++)
            queue_cmd(random_code(), random_level(), random_level(), random_level());

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while ((cmds_to_send.size() != 0 || cmds_accepted != cmds_issued ||
                light_words_due.size() != 0) && cycle_count < RUN_LIMIT)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (cycle_count >= RUN_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still due", cycle_count,
                     light_words_due.size());
            $display("ws2812_spi_frame_encoder_unit_test: done, errors");
        end
        else
        begin
            if (light_words_due.size() != 0)
            begin
                $display("%0d expected words never arrived", light_words_due.size());
                mismatches = mismatches + light_words_due.size();
            end
            $display("sent %0d light commands (%0d refreshes), checked %0d output words",
                     cmds_accepted, refreshes_seen, words_checked);
            $display("mismatching words: %0d", mismatches);
            if (mismatches == 0)
                $display("ws2812_spi_frame_encoder_unit_test: done, clean");
            else
                $display("ws2812_spi_frame_encoder_unit_test: done, errors");
        end
        $finish;
    end

endmodule
